>>> sv/bfp_pkg.sv
package bfp_pkg;

  // Default store size in bytes
  localparam int STORE_BYTES_DEF = 256;

  // Command codes on the action port
  localparam logic [2:0] ACT_SEEK   = 3'd0;
  localparam logic [2:0] ACT_PACK   = 3'd1;
  localparam logic [2:0] ACT_UNPACK = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Source of value_out at the end of a command
  typedef enum logic [1:0] {
    RES_NONE,
    RES_FIELD,
    RES_BYTE
  } res_t;

  // Microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_FIN        = 3'd0;
  localparam step_t ST_PACK       = 3'd1;
  localparam step_t ST_PACK_END   = 3'd2;
  localparam step_t ST_UNPACK     = 3'd3;
  localparam step_t ST_UNPACK_END = 3'd4;
  localparam step_t ST_WRB        = 3'd5;
  localparam step_t ST_RDB        = 3'd6;
  localparam step_t ST_RDB_END    = 3'd7;

  // One control word
  typedef struct packed {
    logic strm;     // stream bytes: read while bytes remain, handle returned data
    logic wr_back;  // returned byte is merged and written back (else accumulated)
    logic byte_wr;  // direct byte write
    logic byte_rd;  // direct byte read
    logic loop;     // hold this step while bytes remain to be read
    logic fin;      // present the result and go idle
    res_t res;
  } uop_t;

  // Microcode ROM
  function automatic uop_t ucode(step_t s);
    uop_t u;
    u = '0;
    unique case (s)
      ST_FIN: begin
        u.fin = 1'b1;
      end
      ST_PACK: begin
        u.strm    = 1'b1;
        u.wr_back = 1'b1;
        u.loop    = 1'b1;
      end
      ST_PACK_END: begin
        u.fin = 1'b1;
      end
      ST_UNPACK: begin
        u.strm = 1'b1;
        u.loop = 1'b1;
      end
      ST_UNPACK_END: begin
        u.fin = 1'b1;
        u.res = RES_FIELD;
      end
      ST_WRB: begin
        u.byte_wr = 1'b1;
        u.fin     = 1'b1;
      end
      ST_RDB: begin
        u.byte_rd = 1'b1;
      end
      ST_RDB_END: begin
        u.fin = 1'b1;
        u.res = RES_BYTE;
      end
      default: begin
        u.fin = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

>>> sv/bit_field_pack_unpack_top.sv
// Bit-field packer over a byte store with a bit cursor. A command is taken
// when start is high and busy is low; its result appears on value_out,
// cursor_byte, cursor_bit and error for exactly one cycle with done high,
// and the receiver cannot stall it. busy drops in the cycle done is high, so
// the next command can start there. Pack and unpack stream the k touched
// bytes (k = 0..5) through the store's single read and single write port,
// one byte per cycle with read and write overlapped. Seek, refused and
// unused commands go straight to the final step, byte write writes its byte
// in the final step, and byte read reads the byte and then presents it.
// A microcode table sequences each command.
module bit_field_pack_unpack_top
  import bfp_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [31:0] value_in,
  input  logic [5:0]  bit_count,
  input  logic [8:0]  byte_index,
  input  logic [2:0]  bit_index,
  input  logic [7:0]  byte_in,
  output logic        done,
  output logic [31:0] value_out,
  output logic [8:0]  cursor_byte,
  output logic [2:0]  cursor_bit,
  output logic        error
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = $clog2(STORE_BYTES + 1);
  localparam int PW = CW + 3;

  // Sequencer
  logic  active;
  step_t step;
  uop_t  uop;

  // Datapath registers
  logic [PW-1:0] pos;
  logic [2:0]    sh;
  logic [2:0]    left;
  logic [2:0]    slot;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [39:0]   val_win;
  logic [39:0]   mask_win;
  logic [39:0]   acc;
  logic [7:0]    rdata;
  logic          rvalid;
  logic          err;

  logic [7:0]    mem [STORE_BYTES];

  // Command decode
  logic          accept;
  logic          n_zero;
  logic [6:0]    span;
  logic [31:0]   last_byte;
  logic          field_err;
  logic          seek_err;
  logic          byte_err;
  logic [2:0]    nbytes;
  logic [31:0]   fmask;
  logic          cmd_err;
  step_t         entry;
  logic [PW-1:0] pos_next;
  logic          byte_op;

  // Memory control
  logic          mem_re;
  logic          mem_we;
  logic [7:0]    wdata;
  logic [7:0]    win_val;
  logic [7:0]    win_mask;
  logic [31:0]   field;

  assign busy   = active;
  assign accept = start & ~active;
  assign uop    = ucode(step);

  // Field bounds against the current cursor
  assign n_zero    = (bit_count == 6'd0);
  assign span      = {4'b0, pos[2:0]} + {1'b0, bit_count} - 7'd1;
  assign last_byte = 32'(pos[PW-1:3]) + 32'(span[5:3]);
  assign field_err = (bit_count > 6'd32) ||
                     (!n_zero && (last_byte >= 32'(STORE_BYTES)));
  assign nbytes    = n_zero ? 3'd0 : span[5:3] + 3'd1;
  assign fmask     = bit_count[5] ? 32'hFFFF_FFFF : (32'd1 << bit_count[4:0]) - 32'd1;
  assign seek_err  = (32'(byte_index) > 32'(STORE_BYTES)) ||
                     ((32'(byte_index) == 32'(STORE_BYTES)) && (bit_index != 3'd0));
  assign byte_err  = (32'(byte_index) >= 32'(STORE_BYTES));
  assign byte_op   = (action == ACT_WRITE) || (action == ACT_READ);

  // Dispatch and cursor update per command
  always_comb begin
    cmd_err  = 1'b0;
    entry    = ST_FIN;
    pos_next = pos;
    unique case (action)
      ACT_SEEK: begin
        cmd_err = seek_err;
        if (!seek_err) begin
          pos_next = PW'({byte_index, bit_index});
        end
      end
      ACT_PACK, ACT_UNPACK: begin
        cmd_err = field_err;
        if (!field_err) begin
          pos_next = pos + PW'(bit_count);
          entry    = (action == ACT_PACK) ? ST_PACK : ST_UNPACK;
        end
      end
      ACT_WRITE: begin
        cmd_err = byte_err;
        if (!byte_err) begin
          entry = ST_WRB;
        end
      end
      ACT_READ: begin
        cmd_err = byte_err;
        if (!byte_err) begin
          entry = ST_RDB;
        end
      end
      default: begin
        cmd_err = 1'b0;
      end
    endcase
  end

  // Byte lane of the current returned byte
  assign win_val  = val_win[{slot, 3'b000} +: 8];
  assign win_mask = mask_win[{slot, 3'b000} +: 8];

  assign mem_re = active && (uop.byte_rd || (uop.strm && (left != 3'd0)));
  assign mem_we = active && (uop.byte_wr || (uop.strm && uop.wr_back && rvalid));
  assign wdata  = uop.byte_wr ? val_win[7:0] : ((rdata & ~win_mask) | (win_val & win_mask));
  assign field  = 32'((acc & mask_win) >> sh);

  // Store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr];
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= ST_FIN;
      pos    <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
      err    <= 1'b0;
    end else begin
      done   <= 1'b0;
      rvalid <= active && uop.strm && (left != 3'd0);
      if (accept) begin
        active <= 1'b1;
        step   <= entry;
        pos    <= pos_next;
        err    <= cmd_err;
      end else if (active) begin
        if (uop.fin) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else if (!(uop.loop && (left != 3'd0))) begin
          step <= step + step_t'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      sh       <= pos[2:0];
      left     <= nbytes;
      slot     <= 3'd0;
      acc      <= '0;
      mask_win <= {8'b0, fmask} << pos[2:0];
      val_win  <= (action == ACT_WRITE) ? {32'b0, byte_in}
                                        : ({8'b0, value_in} << pos[2:0]);
      rd_addr  <= byte_op ? AW'(byte_index) : AW'(pos[PW-1:3]);
      wr_addr  <= byte_op ? AW'(byte_index) : AW'(pos[PW-1:3]);
    end else if (active) begin
      // Issue next read of the stream
      if (uop.strm && (left != 3'd0)) begin
        left    <= left - 3'd1;
        rd_addr <= rd_addr + AW'(1);
      end
      // Handle returned byte: merge and write back, or accumulate
      if (uop.strm && rvalid) begin
        slot <= slot + 3'd1;
        if (uop.wr_back) begin
          wr_addr <= wr_addr + AW'(1);
        end else begin
          acc[{slot, 3'b000} +: 8] <= rdata;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (active && uop.fin) begin
      cursor_byte <= 9'(pos[PW-1:3]);
      cursor_bit  <= pos[2:0];
      error       <= err;
      unique case (uop.res)
        RES_FIELD: value_out <= field;
        RES_BYTE:  value_out <= {24'b0, rdata};
        default:   value_out <= 32'd0;
      endcase
    end
  end

endmodule

>>> tb/tb_bit_field_pack_unpack_top.sv
module tb_bit_field_pack_unpack_top;
  import bfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBYTES = STORE_BYTES_DEF;

  // Action codes the block ignores
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
    logic [5:0]  count;
    logic [8:0]  bidx;
    logic [2:0]  bbit;
    logic [7:0]  bdata;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  cbyte;
    logic [2:0]  cbit;
    logic        err;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [31:0] value_in = '0;
  logic [5:0]  bit_count = '0;
  logic [8:0]  byte_index = '0;
  logic [2:0]  bit_index = '0;
  logic [7:0]  byte_in = '0;
  logic        done;
  logic [31:0] value_out;
  logic [8:0]  cursor_byte;
  logic [2:0]  cursor_bit;
  logic        error;

  // Shadow of the block: store and bit cursor
  logic [7:0]  shadow_store [NBYTES];
  logic [8:0]  shadow_byte = '0;
  logic [2:0]  shadow_bit = '0;

  outcome_t    pending_results [$];
  outcome_t    oldest;
  int          mismatches = 0;
  int          burst_left = 1;

  bit_field_pack_unpack_top #(
    .STORE_BYTES (NBYTES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .value_in    (value_in),
    .bit_count   (bit_count),
    .byte_index  (byte_index),
    .bit_index   (bit_index),
    .byte_in     (byte_in),
    .done        (done),
    .value_out   (value_out),
    .cursor_byte (cursor_byte),
    .cursor_bit  (cursor_bit),
    .error       (error)
  );

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one command to the shadow state and return what the block reports
  function automatic outcome_t apply_cmd(cmd_t c);
    outcome_t o;
    int pos;
    int p;
    int n;
    o = '0;
    n = int'(c.count);
    pos = int'(shadow_byte) * 8 + int'(shadow_bit);
    case (c.action)
      ACT_SEEK: begin
        if (int'(c.bidx) * 8 + int'(c.bbit) > NBYTES * 8) begin
          o.err = 1'b1;
        end else begin
          shadow_byte = c.bidx;
          shadow_bit  = c.bbit;
        end
      end
      ACT_PACK, ACT_UNPACK: begin
        if (n > 32 || (n != 0 && ((pos + n - 1) >> 3) >= NBYTES)) begin
          o.err = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            p = pos + i;
            if (c.action == ACT_PACK) shadow_store[p >> 3][p & 7] = c.value[i];
            else o.value[i] = shadow_store[p >> 3][p & 7];
          end
          pos = pos + n;
          shadow_byte = 9'(pos >> 3);
          shadow_bit  = 3'(pos & 7);
        end
      end
      ACT_WRITE: begin
        if (int'(c.bidx) >= NBYTES) o.err = 1'b1;
        else shadow_store[c.bidx] = c.bdata;
      end
      ACT_READ: begin
        if (int'(c.bidx) >= NBYTES) o.err = 1'b1;
        else o.value = {24'd0, shadow_store[c.bidx]};
      end
      default: ;
    endcase
    o.cbyte = shadow_byte;
    o.cbit  = shadow_bit;
    return o;
  endfunction

  function automatic cmd_t mk(logic [2:0] a, logic [31:0] v, logic [5:0] n,
                              logic [8:0] bi, logic [2:0] bb, logic [7:0] d);
    cmd_t c;
    c = '{action: a, value: v, count: n, bidx: bi, bbit: bb, bdata: d};
    return c;
  endfunction

  // Drop start and let the given number of cycles pass
  task automatic hold_off(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Wait until every expected result has come back
  task automatic drain();
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One command transfer, with bursty pacing on the sender side
  task automatic send_cmd(cmd_t c);
    @(negedge clk);
    start      = 1'b1;
    action     = c.action;
    value_in   = c.value;
    bit_count  = c.count;
    byte_index = c.bidx;
    bit_index  = c.bbit;
    byte_in    = c.bdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_cmd(c));
    burst_left--;
    if (burst_left <= 0) begin
      hold_off($urandom_range(1, 8));
      // occasionally a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value_out=%h", value_out);
      end else begin
        oldest = pending_results.pop_front();
        if (value_out !== oldest.value || cursor_byte !== oldest.cbyte ||
            cursor_bit !== oldest.cbit || error !== oldest.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%h cur=%0d.%0d err=%b, got value=%h cur=%0d.%0d err=%b",
                     oldest.value, oldest.cbyte, oldest.cbit, oldest.err,
                     value_out, cursor_byte, cursor_bit, error);
        end
      end
    end
  end

  // Every store byte gets defined contents before any read
  task automatic test_fill_store();
    for (int i = 0; i < NBYTES; i++) begin
      send_cmd(mk(ACT_WRITE, $urandom, 6'($urandom), 9'(i), 3'($urandom),
                  (i == 0) ? 8'h00 : (i == NBYTES - 1) ? 8'hFF : 8'($urandom)));
    end
    drain();
  endtask

  // Byte access at and past the end of the store
  task automatic test_byte_access();
    send_cmd(mk(ACT_READ,  '0, '0, 9'd0,   3'd0, 8'h00));
    send_cmd(mk(ACT_READ,  '0, '0, 9'd255, 3'd0, 8'h00));
    send_cmd(mk(ACT_READ,  '0, '0, 9'd256, 3'd0, 8'h00));
    send_cmd(mk(ACT_WRITE, '0, '0, 9'd511, 3'd7, 8'hFF));
    send_cmd(mk(ACT_WRITE, '0, '0, 9'd256, 3'd0, 8'h5A));
    send_cmd(mk(ACT_READ,  '0, '0, 9'd511, 3'd7, 8'h00));
    drain();
  endtask

  // Seek to the exact end, just past it, and far past it
  task automatic test_seek_edges();
    send_cmd(mk(ACT_SEEK, '0, '0, 9'd256, 3'd0, '0));
    send_cmd(mk(ACT_SEEK, '0, '0, 9'd256, 3'd1, '0));
    send_cmd(mk(ACT_SEEK, '0, '0, 9'd511, 3'd7, '0));
    drain();
  endtask

  // Zero counts at the end, bad counts, full-width fields at odd offsets
  task automatic test_field_edges();
    send_cmd(mk(ACT_PACK,   32'hFFFF_FFFF, 6'd0,  '0, '0, '0));
    send_cmd(mk(ACT_UNPACK, '0,            6'd0,  '0, '0, '0));
    send_cmd(mk(ACT_PACK,   32'h1,         6'd1,  '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd255, 3'd7, '0));
    send_cmd(mk(ACT_PACK,   32'h1,         6'd1,  '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd0, 3'd0, '0));
    send_cmd(mk(ACT_PACK,   32'hFFFF_FFFF, 6'd32, '0, '0, '0));
    send_cmd(mk(ACT_PACK,   32'h0,         6'd33, '0, '0, '0));
    send_cmd(mk(ACT_UNPACK, '0,            6'd63, '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd10, 3'd3, '0));
    send_cmd(mk(ACT_PACK,   32'hA5A5_F00F, 6'd32, '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd10, 3'd3, '0));
    send_cmd(mk(ACT_UNPACK, '0,            6'd32, '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd251, 3'd7, '0));
    send_cmd(mk(ACT_PACK,   32'h0,         6'd32, '0, '0, '0));
    send_cmd(mk(ACT_SEEK,   '0, '0, 9'd252, 3'd1, '0));
    send_cmd(mk(ACT_PACK,   32'hFFFF_FFFF, 6'd32, '0, '0, '0));
    drain();
  endtask

  task automatic test_spare_actions();
    send_cmd(mk(ACT_SPARE_5, 32'hFFFF_FFFF, 6'd63, 9'd511, 3'd7, 8'hFF));
    send_cmd(mk(ACT_SPARE_6, '0, 6'd8, 9'd4, 3'd2, 8'h11));
    send_cmd(mk(ACT_SPARE_7, $urandom, 6'($urandom), 9'($urandom), 3'($urandom),
                8'($urandom)));
    drain();
  endtask

  // Pack a run of fields, seek back, unpack them again
  task automatic test_round_trips(int sequences);
    int k;
    logic [8:0] b0;
    logic [2:0] s0;
    logic [5:0] counts [8];
    for (int s = 0; s < sequences; s++) begin
      k  = $urandom_range(1, 6);
      b0 = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(220, 256))
                                       : 9'($urandom_range(0, 225));
      s0 = 3'($urandom);
      for (int j = 0; j < k; j++)
        counts[j] = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
      send_cmd(mk(ACT_SEEK, $urandom, 6'($urandom), b0, s0, 8'($urandom)));
      for (int j = 0; j < k; j++)
        send_cmd(mk(ACT_PACK, $urandom, counts[j], 9'($urandom), 3'($urandom),
                    8'($urandom)));
      send_cmd(mk(ACT_SEEK, $urandom, 6'($urandom), b0, s0, 8'($urandom)));
      for (int j = 0; j < k; j++)
        send_cmd(mk(ACT_UNPACK, $urandom, counts[j], 9'($urandom), 3'($urandom),
                    8'($urandom)));
      if ($urandom_range(0, 3) == 0)
        send_cmd(mk(ACT_READ, $urandom, 6'($urandom), b0, 3'($urandom),
                    8'($urandom)));
      if (s % 25 == 24) drain();
    end
    drain();
  endtask

  // Single commands with random fields and weighted actions
  task automatic test_random_mix(int items);
    cmd_t c;
    int pick;
    for (int i = 0; i < items; i++) begin
      c = mk('0, $urandom, 6'($urandom), 9'($urandom), 3'($urandom), 8'($urandom));
      if ($urandom_range(0, 6) != 0) c.count = 6'($urandom_range(0, 32));
      if ($urandom_range(0, 4) != 0) c.bidx  = 9'($urandom_range(0, 256));
      pick = $urandom_range(0, 99);
      if (pick < 30)      c.action = ACT_PACK;
      else if (pick < 60) c.action = ACT_UNPACK;
      else if (pick < 78) c.action = ACT_SEEK;
      else if (pick < 87) c.action = ACT_WRITE;
      else if (pick < 96) c.action = ACT_READ;
      else if (pick < 97) c.action = ACT_SPARE_5;
      else if (pick < 98) c.action = ACT_SPARE_6;
      else                c.action = ACT_SPARE_7;
      send_cmd(c);
      if (i % 200 == 199) drain();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_store();
    test_byte_access();
    test_seek_edges();
    test_field_edges();
    test_spare_actions();
    test_round_trips(80);
    test_random_mix(800);

    drain();
    repeat (20) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
